// ===== rtl/ntc_pkg.sv =====
// Shared constants, datapath operation codes and control/status types.
package ntc_pkg;

    localparam int C_ADC_BITS = 12;

    // Configuration register indexes and reset values
    localparam logic [1:0]  CFG_RREF = 2'd0;
    localparam logic [1:0]  CFG_BETA = 2'd1;
    localparam logic [1:0]  CFG_RINF = 2'd2;
    localparam logic [19:0] RREF_RST = 20'd10000;
    localparam logic [13:0] BETA_RST = 14'd3380;
    localparam logic [23:0] RINF_RST = 24'd2001279;

    // Arithmetic constants
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [17:0] ABS_ZERO_Q8 = 18'd69926;
    localparam logic [17:0] TEMP_MAX    = 18'd70000;
    localparam logic [46:0] TK_MAX      = 47'd139926;
    localparam logic [5:0]  SQR_STEPS   = 6'd24;
    localparam logic [5:0]  DIV_STEPS   = 6'd47;

    // Datapath operation codes
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_MUL    = 4'd2;
    localparam logic [3:0] OP_LOGN   = 4'd3;
    localparam logic [3:0] OP_LOGD   = 4'd4;
    localparam logic [3:0] OP_NORM   = 4'd5;
    localparam logic [3:0] OP_MANT   = 4'd6;
    localparam logic [3:0] OP_SQR    = 4'd7;
    localparam logic [3:0] OP_DIFF   = 4'd8;
    localparam logic [3:0] OP_LN     = 4'd9;
    localparam logic [3:0] OP_DINIT  = 4'd10;
    localparam logic [3:0] OP_DIV    = 4'd11;
    localparam logic [3:0] OP_FIN_OK = 4'd12;
    localparam logic [3:0] OP_FIN_SAT = 4'd13;
    localparam logic [3:0] OP_PUSH   = 4'd14;

    typedef struct packed {
        logic [3:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic invalid;    // den is zero or num <= den
        logic norm_top;   // normalized word has its top bit set
        logic step_last;  // last squaring or divide step
        logic log_small;  // log difference <= 0
        logic ln_zero;    // natural log rounds to zero
    } t_dp_sts;

endpackage

// ===== rtl/ntc_thermistor_ratiometric_reader.sv =====
// Top level of the NTC thermistor divider sequencer and temperature reader.
//
// Input channel (i_in_valid/o_in_ready) takes one item: a finished ADC
// conversion (req_type 0) or a temperature read (req_type 1). Every item
// gives exactly one result on the output channel (o_out_valid/i_out_ready):
// temperature in 1/256 degC, its valid flag, divider pin levels and a start
// flag for the next conversion.
// A conversion item is loaded on accept and pushed to the output register
// from the done state once that register is free; the next item can be
// taken after the push. A valid read runs from accept to result through
// two log2 passes, each a normalize and 24 squarings on one 32x32
// multiplier, then a 47-step restoring divider. An invalid read goes from
// the check to the push; a read whose log saturates ends after the squarings.
// Items are processed one at a time; o_in_ready is high only while the
// controller is idle.
// A finished result sits in an output register, so the next item is accepted
// while it waits; if the receiver stalls longer, the following result holds
// in the datapath until the register frees.
// Reset (synchronous, active low) restores the default resistor, beta and
// R-infinity values, the thermistor phase and zero samples and pin levels.
// Configuration writes take effect at once and are meant for idle periods.
module ntc_thermistor_ratiometric_reader
    import ntc_pkg::*;
#(
    parameter int ADC_BITS = C_ADC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_req_type,
    input  logic [ADC_BITS-1:0] i_adc_counts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [17:0]  o_temperature_q8,
    output logic                o_temperature_valid,
    output logic                o_vdd_pin_level,
    output logic                o_gnd_pin_level,
    output logic                o_start_conversion,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [23:0]         i_cfg_data
);
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ntc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ntc_dp #(.ADC_BITS(ADC_BITS)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_req_type          (i_req_type),
        .i_adc_counts        (i_adc_counts),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .o_temperature_q8    (o_temperature_q8),
        .o_temperature_valid (o_temperature_valid),
        .o_vdd_pin_level     (o_vdd_pin_level),
        .o_gnd_pin_level     (o_gnd_pin_level),
        .o_start_conversion  (o_start_conversion)
    );

endmodule

// ===== rtl/ntc_dp.sv =====
// Datapath: divider state, config registers, log2 unit, divider and result registers.
module ntc_dp
    import ntc_pkg::*;
#(
    parameter int ADC_BITS = C_ADC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_req_type,
    input  logic [ADC_BITS-1:0] i_adc_counts,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [23:0]         i_cfg_data,
    output logic signed [17:0]  o_temperature_q8,
    output logic                o_temperature_valid,
    output logic                o_vdd_pin_level,
    output logic                o_gnd_pin_level,
    output logic                o_start_conversion
);
    localparam int PW = 20 + ADC_BITS;
    localparam int DW = ADC_BITS + 24;

    logic                r_phase, r_vdd, r_gnd, r_start;
    logic [ADC_BITS-1:0] r_ref_s, r_thm_s;
    logic [19:0]         r_rref;
    logic [13:0]         r_beta;
    logic [23:0]         r_rinf;
    logic [63:0]         r_num, r_den, r_x;
    logic [5:0]          r_e, r_cnt;
    logic [31:0]         r_m;
    logic [23:0]         r_frac;
    logic [29:0]         r_log_n, r_ln;
    logic signed [30:0]  r_d;
    logic [30:0]         r_rem;
    logic [46:0]         r_quo;
    logic signed [17:0]  r_temp, r_out_temp;
    logic                r_tvalid, r_out_tvalid, r_out_vdd, r_out_gnd, r_out_start;

    logic [PW-1:0] w_nprod;
    logic [DW-1:0] w_dprod;
    logic [63:0]   w_sq;
    logic [61:0]   w_lp;
    logic [31:0]   w_trial;

    assign w_nprod = PW'(r_rref) * PW'(r_thm_s);
    assign w_dprod = DW'(r_ref_s) * DW'(r_rinf);
    assign w_sq    = 64'(r_m) * 64'(r_m);
    assign w_lp    = 62'(r_d[29:0]) * 62'(LN2_Q32);
    assign w_trial = {r_rem, r_quo[46]} - {2'b00, r_ln};

    // Report status to the controller
    always_comb begin
        o_sts.invalid   = (r_den == 64'd0) || (r_num <= r_den);
        o_sts.norm_top  = r_x[63];
        o_sts.step_last = (r_cnt == 6'd1);
        o_sts.log_small = r_d[30] || (r_d == 31'sd0);
        o_sts.ln_zero   = (r_ln == 30'd0);
    end

    // Hold configuration and divider state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rref  <= RREF_RST;
            r_beta  <= BETA_RST;
            r_rinf  <= RINF_RST;
            r_phase <= 1'b0;
            r_ref_s <= '0;
            r_thm_s <= '0;
            r_vdd   <= 1'b0;
            r_gnd   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RREF: r_rref <= i_cfg_data[19:0];
                    CFG_BETA: r_beta <= i_cfg_data[13:0];
                    CFG_RINF: r_rinf <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_LOAD) begin
                if (!i_req_type) begin
                    if (r_phase) begin
                        r_ref_s <= i_adc_counts;
                        r_vdd   <= 1'b0;
                        r_gnd   <= 1'b1;
                    end else begin
                        r_thm_s <= i_adc_counts;
                        r_vdd   <= 1'b0;
                    end
                    r_phase <= ~r_phase;
                end else begin
                    r_vdd <= ~r_phase;
                    r_gnd <= r_phase;
                end
            end
        end
    end

    // Run the arithmetic operations
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_start  <= i_req_type | r_phase;
                r_temp   <= '0;
                r_tvalid <= 1'b0;
            end
            OP_MUL: begin
                r_num <= {{(64-PW-24){1'b0}}, w_nprod, 24'd0};
                r_den <= {{(64-DW){1'b0}}, w_dprod};
            end
            OP_LOGN: begin
                r_x    <= r_num;
                r_e    <= 6'd63;
                r_frac <= '0;
            end
            OP_LOGD: begin
                r_log_n <= {r_e, r_frac};
                r_x     <= r_den;
                r_e     <= 6'd63;
                r_frac  <= '0;
            end
            OP_NORM: begin
                if (r_x[63:56] == 8'd0) begin
                    r_x <= {r_x[55:0], 8'd0};
                    r_e <= r_e - 6'd8;
                end else begin
                    r_x <= {r_x[62:0], 1'b0};
                    r_e <= r_e - 6'd1;
                end
            end
            OP_MANT: begin
                r_m   <= r_x[63:32];
                r_cnt <= SQR_STEPS;
            end
            OP_SQR: begin
                r_frac <= {r_frac[22:0], w_sq[63]};
                r_m    <= w_sq[63] ? w_sq[63:32] : w_sq[62:31];
                r_cnt  <= r_cnt - 6'd1;
            end
            OP_DIFF: r_d <= $signed({1'b0, r_log_n}) - $signed({1'b0, r_e, r_frac});
            OP_LN:   r_ln <= w_lp[61:32];
            OP_DINIT: begin
                r_quo <= {1'b0, r_beta, 32'd0} + 47'(r_ln[29:1]);
                r_rem <= '0;
                r_cnt <= DIV_STEPS;
            end
            OP_DIV: begin
                if (!w_trial[31]) begin
                    r_rem <= w_trial[30:0];
                    r_quo <= {r_quo[45:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[29:0], r_quo[46]};
                    r_quo <= {r_quo[45:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
            end
            OP_FIN_OK: begin
                r_temp   <= (r_quo > TK_MAX) ? $signed(TEMP_MAX)
                                             : $signed(r_quo[17:0] - ABS_ZERO_Q8);
                r_tvalid <= 1'b1;
            end
            OP_FIN_SAT: begin
                r_temp   <= $signed(TEMP_MAX);
                r_tvalid <= 1'b1;
            end
            OP_PUSH: begin
                r_out_temp   <= r_temp;
                r_out_tvalid <= r_tvalid;
                r_out_vdd    <= r_vdd;
                r_out_gnd    <= r_gnd;
                r_out_start  <= r_start;
            end
            default: ;
        endcase
    end

    assign o_temperature_q8    = r_out_temp;
    assign o_temperature_valid = r_out_tvalid;
    assign o_vdd_pin_level     = r_out_vdd;
    assign o_gnd_pin_level     = r_out_gnd;
    assign o_start_conversion  = r_out_start;

endmodule

// ===== rtl/ntc_ctrl.sv =====
// Controller: sequences one item through the datapath and owns the output handshake.
module ntc_ctrl
    import ntc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_req_type,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MUL   = 5'd1;
    localparam logic [4:0] S_CHK   = 5'd2;
    localparam logic [4:0] S_NORMN = 5'd3;
    localparam logic [4:0] S_SQRN  = 5'd4;
    localparam logic [4:0] S_LOGD  = 5'd5;
    localparam logic [4:0] S_NORMD = 5'd6;
    localparam logic [4:0] S_SQRD  = 5'd7;
    localparam logic [4:0] S_DIFF  = 5'd8;
    localparam logic [4:0] S_CHKD  = 5'd9;
    localparam logic [4:0] S_CHKLN = 5'd10;
    localparam logic [4:0] S_DINIT = 5'd11;
    localparam logic [4:0] S_DIV   = 5'd12;
    localparam logic [4:0] S_FIN   = 5'd13;
    localparam logic [4:0] S_SAT   = 5'd14;
    localparam logic [4:0] S_DONE  = 5'd15;

    logic [4:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    // Pick the next state and the datapath operation
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = i_req_type ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_sts.invalid) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_LOGN;
                    n_state  = S_NORMN;
                end
            end
            S_NORMN: begin
                o_cmd.op = i_sts.norm_top ? OP_MANT : OP_NORM;
                if (i_sts.norm_top) n_state = S_SQRN;
            end
            S_SQRN: begin
                o_cmd.op = OP_SQR;
                if (i_sts.step_last) n_state = S_LOGD;
            end
            S_LOGD: begin
                o_cmd.op = OP_LOGD;
                n_state  = S_NORMD;
            end
            S_NORMD: begin
                o_cmd.op = i_sts.norm_top ? OP_MANT : OP_NORM;
                if (i_sts.norm_top) n_state = S_SQRD;
            end
            S_SQRD: begin
                o_cmd.op = OP_SQR;
                if (i_sts.step_last) n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_CHKD;
            end
            S_CHKD: begin
                if (i_sts.log_small) begin
                    n_state = S_SAT;
                end else begin
                    o_cmd.op = OP_LN;
                    n_state  = S_CHKLN;
                end
            end
            S_CHKLN: n_state = i_sts.ln_zero ? S_SAT : S_DINIT;
            S_DINIT: begin
                o_cmd.op = OP_DINIT;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_sts.step_last) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.op = OP_FIN_OK;
                n_state  = S_DONE;
            end
            S_SAT: begin
                o_cmd.op = OP_FIN_SAT;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // push once the output register is free
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = OP_PUSH;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule
